// ===== rtl/bfbp_pkg.sv =====
// Shared types, constants and helpers for the bitmap fixed block pool.
// No dependencies; imported by every module of the block.
package bfbp_pkg;

  localparam int MAX_POOLS      = 8;
  localparam int MAX_SLOTS      = 256;
  localparam int WORD_BITS      = 32;
  localparam int OFFSET_BITS    = 24;
  localparam int WORDS_PER_POOL = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_BITS     = $clog2(MAX_POOLS);
  localparam int WIDX_BITS      = $clog2(WORDS_PER_POOL);
  localparam int BIDX_BITS      = $clog2(WORD_BITS);
  localparam int SLOT_BITS      = $clog2(MAX_SLOTS);
  localparam int MEM_DEPTH      = MAX_POOLS * WORDS_PER_POOL;
  localparam int MEM_AW         = $clog2(MEM_DEPTH);
  localparam int ADDR_W         = 27;

  // configuration register indexes
  localparam int REG_OBJ_BYTES  = 0;
  localparam int REG_SLOTS      = 1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_SIZE      = 3'd1,
    STAT_NO_POOL   = 3'd2,
    STAT_NOT_OWNED = 3'd3,
    STAT_DOUBLE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_RELEASE,
    OP_NOP,
    OP_SIZE_ERR
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AL_PICK,
    S_AL_CHECK,
    S_AL_OPEN,
    S_ADDR,
    S_FR_LIM,
    S_FR_CHK,
    S_FR_DIV,
    S_FR_CHECK,
    S_ACT1,
    S_ACT2
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [15:0]       request_bytes;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic [ADDR_W-1:0] current_bytes;
    logic [ADDR_W-1:0] peak_bytes;
    logic [ADDR_W-1:0] actual_bytes;
    logic [3:0]        pool_count;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
  } q_item_t;

  function automatic logic [15:0] eff_obj(input logic [15:0] v);
    eff_obj = (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [8:0] eff_slots(input logic [8:0] v);
    if (v == 9'd0) eff_slots = 9'd1;
    else if (v > 9'(MAX_SLOTS)) eff_slots = 9'(MAX_SLOTS);
    else eff_slots = v;
  endfunction

endpackage

// ===== rtl/bfbp_front.sv =====
// Front end: classifies incoming commands and queues them for the back end.
// Depends on bfbp_pkg.
module bfbp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bfbp_pkg::in_item_t in_data,
  input  logic [15:0]        obj_bytes,
  output logic               q_valid,
  output bfbp_pkg::q_item_t  q_item,
  input  logic               q_pop
);
  import bfbp_pkg::*;

  q_item_t    fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  q_item_t    cls;
  logic       push;

  always_comb begin
    cls.addr = in_data.block_address;
    case (in_data.cmd)
      CMD_ALLOC: begin
        if (in_data.request_bytes != 16'd0 && in_data.request_bytes != eff_obj(obj_bytes))
          cls.op = OP_SIZE_ERR;
        else
          cls.op = OP_ALLOC;
      end
      CMD_FREE:    cls.op = OP_FREE;
      CMD_RELEASE: cls.op = OP_RELEASE;
      default:     cls.op = OP_NOP;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== rtl/bfbp_div.sv =====
// Restoring divider: byte offset by object size, one quotient bit per cycle.
// Depends on bfbp_pkg; the quotient is known to fit in SLOT_BITS.
module bfbp_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [bfbp_pkg::OFFSET_BITS-1:0] dividend,
  input  logic [15:0]                      divisor,
  output logic                             done,
  output logic [bfbp_pkg::SLOT_BITS-1:0]   quotient
);
  import bfbp_pkg::*;

  logic                   busy_r, busy_nxt, done_r, done_nxt;
  logic [SLOT_BITS-1:0]   step_r, step_nxt;
  logic [OFFSET_BITS-1:0] rem_r, rem_nxt, trial;
  logic [SLOT_BITS-1:0]   q_r, q_nxt;
  logic [15:0]            dvs_r, dvs_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    trial    = OFFSET_BITS'(dvs_r) << step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = SLOT_BITS'(SLOT_BITS - 1);
      rem_nxt  = dividend;
      dvs_nxt  = divisor;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt        = rem_r - trial;
        q_nxt[step_r[$clog2(SLOT_BITS)-1:0]] = 1'b1;
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/bfbp_back.sv =====
// Back end: pool bookkeeping, bitmap memory and the command sequencer.
// Depends on bfbp_pkg and bfbp_div.
module bfbp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  bfbp_pkg::q_item_t   q_item,
  output logic                q_pop,
  input  logic [15:0]         obj_bytes,
  input  logic [8:0]          slots_per_pool,
  output logic                out_valid,
  input  logic                out_ready,
  output bfbp_pkg::out_item_t out_data
);
  import bfbp_pkg::*;

  state_t                 state_r, state_nxt;
  logic [FRAME_BITS-1:0]  rank_r, rank_nxt, frame_r, frame_nxt;
  logic [WIDX_BITS-1:0]   word_r, word_nxt;
  logic [SLOT_BITS-1:0]   slot_r, slot_nxt;
  status_t                status_r, status_nxt;
  logic [ADDR_W-1:0]      addr_r, addr_nxt, gaddr_r, gaddr_nxt;
  logic [24:0]            lim_r, lim_nxt;
  logic [ADDR_W-1:0]      bytes_r, bytes_nxt, peak_r, peak_nxt;
  logic [MAX_POOLS-1:0]   valid_r, valid_nxt;
  logic [FRAME_BITS-1:0]  age_r [MAX_POOLS];
  logic [FRAME_BITS-1:0]  age_nxt [MAX_POOLS];
  logic [8:0]             cnt_r [MAX_POOLS];
  logic [8:0]             cnt_nxt [MAX_POOLS];
  logic [MEM_DEPTH-1:0]   fresh_r, fresh_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic [WORD_BITS-1:0]   mem [MEM_DEPTH];
  logic [WORD_BITS-1:0]   rd_data_r, mem_wdata;
  logic                   rd_fresh_r, mem_re, mem_we;
  logic [MEM_AW-1:0]      mem_raddr, mem_waddr;

  logic [15:0]            obj;
  logic [8:0]             n;
  logic [3:0]             pool_cnt;
  logic                   pick_hit, inv_hit, has_low, more_words;
  logic [FRAME_BITS-1:0]  pick_f, inv_f;
  logic [WORD_BITS-1:0]   word_now, mask, masked;
  logic [8:0]             remain;
  logic [BIDX_BITS-1:0]   low;
  logic [MAX_POOLS-1:0]   keep;
  logic [FRAME_BITS-1:0]  new_rank;
  logic [27:0]            sum;
  logic [25:0]            base;
  logic [29:0]            act;
  logic                   div_start, div_done;
  logic [SLOT_BITS-1:0]   quot;

  bfbp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (addr_r[OFFSET_BITS-1:0]),
    .divisor  (obj),
    .done     (div_done),
    .quotient (quot)
  );

  assign obj = eff_obj(obj_bytes);
  assign n   = eff_slots(slots_per_pool);

  always_comb begin
    pool_cnt = '0;
    pick_hit = 1'b0;
    pick_f   = '0;
    inv_hit  = 1'b0;
    inv_f    = '0;
    for (int f = 0; f < MAX_POOLS; f++) begin
      pool_cnt = pool_cnt + 4'(valid_r[f]);
      if (!pick_hit && valid_r[f] && age_r[f] == rank_r) begin
        pick_hit = 1'b1;
        pick_f   = FRAME_BITS'(f);
      end
      if (!inv_hit && !valid_r[f]) begin
        inv_hit = 1'b1;
        inv_f   = FRAME_BITS'(f);
      end
    end
  end

  // Bits at or above the slot count never take part in allocation.
  always_comb begin
    word_now   = rd_fresh_r ? '1 : rd_data_r;
    remain     = n - {1'b0, word_r, 5'd0};
    mask       = (remain >= 9'(WORD_BITS)) ? '1 : ((WORD_BITS'(1) << remain[4:0]) - 1'b1);
    masked     = word_now & mask;
    has_low    = 1'b0;
    low        = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (masked[b]) begin
        has_low = 1'b1;
        low     = BIDX_BITS'(b);
      end
    end
    more_words = ({2'b0, word_r, 5'd0} + 10'(WORD_BITS)) < {1'b0, n};
  end

  always_comb begin
    state_nxt     = state_r;
    rank_nxt      = rank_r;
    frame_nxt     = frame_r;
    word_nxt      = word_r;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    gaddr_nxt     = gaddr_r;
    lim_nxt       = lim_r;
    bytes_nxt     = bytes_r;
    peak_nxt      = peak_r;
    valid_nxt     = valid_r;
    age_nxt       = age_r;
    cnt_nxt       = cnt_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    div_start     = 1'b0;
    keep          = '0;
    new_rank      = '0;
    sum           = '0;
    base          = '0;
    act           = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop      = 1'b1;
          addr_nxt   = q_item.addr;
          status_nxt = STAT_OK;
          gaddr_nxt  = '0;
          state_nxt  = S_ACT1;
          case (q_item.op)
            OP_ALLOC: begin
              if (pool_cnt == 4'd0) begin
                state_nxt = S_AL_OPEN;
              end else begin
                rank_nxt  = FRAME_BITS'(pool_cnt - 4'd1);
                state_nxt = S_AL_PICK;
              end
            end
            OP_FREE:     state_nxt = S_FR_LIM;
            OP_SIZE_ERR: status_nxt = STAT_SIZE;
            OP_RELEASE: begin
              for (int f = 0; f < MAX_POOLS; f++)
                keep[f] = valid_r[f] && (cnt_r[f] != n);
              for (int f = 0; f < MAX_POOLS; f++) begin
                new_rank = '0;
                for (int g = 0; g < MAX_POOLS; g++)
                  if (keep[g] && age_r[g] < age_r[f]) new_rank = new_rank + 1'b1;
                age_nxt[f] = keep[f] ? new_rank : '0;
              end
              valid_nxt = keep;
            end
            default: ;
          endcase
        end
      end
      // Walk from the newest pool toward the oldest.
      S_AL_PICK: begin
        if (pick_hit && cnt_r[pick_f] != 9'd0) begin
          frame_nxt = pick_f;
          word_nxt  = '0;
          mem_re    = 1'b1;
          mem_raddr = {pick_f, WIDX_BITS'(0)};
          state_nxt = S_AL_CHECK;
        end else if (rank_r == '0) begin
          state_nxt = S_AL_OPEN;
        end else begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      S_AL_CHECK: begin
        if (has_low) begin
          mem_we             = 1'b1;
          mem_waddr          = {frame_r, word_r};
          mem_wdata          = word_now & ~(WORD_BITS'(1) << low);
          fresh_nxt[{frame_r, word_r}] = 1'b0;
          cnt_nxt[frame_r]   = cnt_r[frame_r] - 1'b1;
          slot_nxt           = {word_r, low};
          state_nxt          = S_ADDR;
        end else if (more_words) begin
          word_nxt  = word_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = {frame_r, word_r + 1'b1};
        end else if (rank_r == '0) begin
          state_nxt = S_AL_OPEN;
        end else begin
          rank_nxt  = rank_r - 1'b1;
          state_nxt = S_AL_PICK;
        end
      end
      // New pool: every slot free, slot zero handed out at once.
      S_AL_OPEN: begin
        if (!inv_hit) begin
          status_nxt = STAT_NO_POOL;
          state_nxt  = S_ACT1;
        end else begin
          frame_nxt        = inv_f;
          valid_nxt[inv_f] = 1'b1;
          age_nxt[inv_f]   = pool_cnt[FRAME_BITS-1:0];
          cnt_nxt[inv_f]   = n - 1'b1;
          for (int w = 0; w < WORDS_PER_POOL; w++)
            fresh_nxt[{inv_f, WIDX_BITS'(w)}] = (w != 0);
          mem_we    = 1'b1;
          mem_waddr = {inv_f, WIDX_BITS'(0)};
          mem_wdata = ~WORD_BITS'(1);
          slot_nxt  = '0;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        gaddr_nxt = {frame_r, OFFSET_BITS'(slot_r * obj)};
        sum       = {1'b0, bytes_r} + 28'(obj);
        bytes_nxt = sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
        if (bytes_nxt > peak_r) peak_nxt = bytes_nxt;
        state_nxt = S_ACT1;
      end
      S_FR_LIM: begin
        lim_nxt   = 25'(obj * n);
        frame_nxt = addr_r[ADDR_W-1 -: FRAME_BITS];
        state_nxt = S_FR_CHK;
      end
      S_FR_CHK: begin
        if (!valid_r[frame_r] || {1'b0, addr_r[OFFSET_BITS-1:0]} >= lim_r) begin
          status_nxt = STAT_NOT_OWNED;
          state_nxt  = S_ACT1;
        end else begin
          div_start = 1'b1;
          state_nxt = S_FR_DIV;
        end
      end
      S_FR_DIV: begin
        if (div_done) begin
          slot_nxt  = quot;
          mem_re    = 1'b1;
          mem_raddr = {frame_r, quot[SLOT_BITS-1 -: WIDX_BITS]};
          state_nxt = S_FR_CHECK;
        end
      end
      S_FR_CHECK: begin
        if (word_now[slot_r[BIDX_BITS-1:0]]) begin
          status_nxt = STAT_DOUBLE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = {frame_r, slot_r[SLOT_BITS-1 -: WIDX_BITS]};
          mem_wdata = word_now | (WORD_BITS'(1) << slot_r[BIDX_BITS-1:0]);
          if (cnt_r[frame_r] < 9'(MAX_SLOTS)) cnt_nxt[frame_r] = cnt_r[frame_r] + 1'b1;
          bytes_nxt = (bytes_r >= ADDR_W'(obj)) ? bytes_r - ADDR_W'(obj) : '0;
        end
        state_nxt = S_ACT1;
      end
      S_ACT1: begin
        lim_nxt   = 25'(obj * n);
        state_nxt = S_ACT2;
      end
      S_ACT2: begin
        base = 26'(lim_r) + 26'(n[8:5]) + 26'd1;
        act  = 30'(pool_cnt) * 30'(base);
        out_data_nxt.status          = status_r;
        out_data_nxt.granted_address = gaddr_r;
        out_data_nxt.current_bytes   = bytes_r;
        out_data_nxt.peak_bytes      = peak_r;
        out_data_nxt.actual_bytes    = (act > 30'({ADDR_W{1'b1}})) ? '1 : act[ADDR_W-1:0];
        out_data_nxt.pool_count      = pool_cnt;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      rd_data_r  <= mem[mem_raddr];
      rd_fresh_r <= fresh_r[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= MAX_POOLS'(1);
      fresh_r     <= MEM_DEPTH'({WORDS_PER_POOL{1'b1}});
      bytes_r     <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
      for (int f = 0; f < MAX_POOLS; f++) begin
        age_r[f] <= '0;
        cnt_r[f] <= (f == 0) ? 9'(MAX_SLOTS) : 9'd0;
      end
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      fresh_r     <= fresh_nxt;
      bytes_r     <= bytes_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
      age_r       <= age_nxt;
      cnt_r       <= cnt_nxt;
    end
    rank_r     <= rank_nxt;
    frame_r    <= frame_nxt;
    word_r     <= word_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
    gaddr_r    <= gaddr_nxt;
    lim_r      <= lim_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_peak_covers_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= bytes_r) else $error("peak below current bytes");
  a_idle_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !q_valid) |=> state_r == S_IDLE)
    else $error("sequencer left idle with no queued item");
  a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_ACT2))
    else $error("result loaded outside the final step");
  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && !out_valid_r))
    else $error("item taken while a result is pending");
`endif

endmodule

// ===== rtl/bitmap_fixed_block_pool_core.sv =====
// Flow, input transfer to result transfer: allocate tries pools in turn, reading bitmap
// words (at most 8 pools x 8 words), and opens a new pool when none has a free slot; free
// runs the 8-step offset divider unless the address is unowned; release, unused and
// size-refused requests go straight to the result. One item in the sequencer at a time,
// started only once the last result is taken; a 2-entry queue takes new items meanwhile.
// Synchronous active-low reset: pool 0 open with all slots free, counters zero, 8/256 regs.
module bitmap_fixed_block_pool_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bfbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bfbp_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bfbp_pkg::*;

  logic [15:0] obj_bytes_r;
  logic [8:0]  slots_r;
  logic        q_valid, q_pop;
  q_item_t     q_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'(REG_OBJ_BYTES)) ? {16'd0, obj_bytes_r} : {23'd0, slots_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_bytes_r <= 16'd8;
      slots_r     <= 9'd256;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'(REG_OBJ_BYTES)) obj_bytes_r <= pwdata[15:0];
      else slots_r <= pwdata[8:0];
    end
  end

  bfbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .obj_bytes (obj_bytes_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  bfbp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .obj_bytes      (obj_bytes_r),
    .slots_per_pool (slots_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule
